// ----- hw/rtl/fpds_pkg.sv -----
// ----------------------------------------------------------------------------
// fpds_pkg
// Shared constants and types for the five-point diffusion stencil: field
// widths, frame limits, register indexes and the result queue entry.
// ----------------------------------------------------------------------------
package fpds_pkg;

  // Field widths
  localparam int VAL_W  = 16;  // Q10.6 cell value
  localparam int COL_W  = 10;  // column / row coordinates
  localparam int DIM_W  = 11;  // frame width / height registers
  localparam int RATE_W = 9;   // diffusion rate, Q1.8
  localparam int CFG_W  = 11;  // configuration write data
  localparam int IDX_W  = 2;   // configuration register index

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_DEPTH = MAX_WIDTH;

  localparam logic [DIM_W-1:0]  MIN_DIM       = DIM_W'(3);
  localparam logic [DIM_W-1:0]  MAX_WIDTH_V   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  MAX_HEIGHT_V  = DIM_W'(MAX_HEIGHT);
  localparam logic [RATE_W-1:0] RATE_ONE      = RATE_W'(256);

  // Register reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(1024);
  localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(26);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DIFFUSE_RATE = IDX_W'(2);

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One queued transaction: the diffused cell one row up, and on the last
  // row the incoming cell as a second result.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;       // row of the incoming cell
    logic [VAL_W-1:0] value;     // diffused value for (row-1, col)
    logic [VAL_W-1:0] value2;    // incoming cell, last row only
    logic             second;    // a second result follows
    logic             last_col;  // incoming cell closes its row
  } queue_entry_t;

endpackage

// ----- hw/rtl/five_point_diffusion_stencil.sv -----
// ----------------------------------------------------------------------------
// five_point_diffusion_stencil
// Streaming five-point diffusion over a raster frame using two line buffers.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    cell_value, frame_start
//  out      out_valid / out_ready  out_col, out_row, out_value, run_last,
//                                  frame_done
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (ready always high)
//
//  One cell per clock while the result queue has room; results are registered.
//  The two line buffers are single-write memories with registered reads,
//  so each cell walks read, multiply, blend before the result queue.
//  The last row gives two results per cell, so output there runs at one
//  result per clock while out_ready is high, and input is held off to match.
//  Input is accepted while the four-entry result queue has room for every
//  transaction in flight; a stalled output only fills the queue.
//  Synchronous reset clears the counters, pipeline and queue; the line
//  buffers are not cleared.
// ----------------------------------------------------------------------------
module five_point_diffusion_stencil
  import fpds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // cell input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VAL_W-1:0]  cell_value,
  input  logic              frame_start,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COL_W-1:0]  out_col,
  output logic [COL_W-1:0]  out_row,
  output logic [VAL_W-1:0]  out_value,
  output logic              run_last,
  output logic              frame_done,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // Configuration registers
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [RATE_W-1:0] diffuse_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      diffuse_rate <= RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_DIFFUSE_RATE: diffuse_rate <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and saturated rate
  logic [DIM_W-1:0]  width_eff;
  logic [DIM_W-1:0]  height_eff;
  logic [RATE_W-1:0] rate_eff;
  logic [RATE_W-1:0] rate_inv;

  always_comb begin
    if (frame_width < MIN_DIM)           width_eff = MIN_DIM;
    else if (frame_width > MAX_WIDTH_V)  width_eff = MAX_WIDTH_V;
    else                                 width_eff = frame_width;
    if (frame_height < MIN_DIM)          height_eff = MIN_DIM;
    else if (frame_height > MAX_HEIGHT_V) height_eff = MAX_HEIGHT_V;
    else                                 height_eff = frame_height;
    rate_eff = (diffuse_rate > RATE_ONE) ? RATE_ONE : diffuse_rate;
    rate_inv = RATE_ONE - rate_eff;
  end

  // ------------------------------------------------------------------
  // Stage 0: position of the accepted cell and counter update
  // ------------------------------------------------------------------
  logic [COL_W-1:0] col_count;
  logic [COL_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [COL_W-1:0] row_count_next;
  logic [DIM_W-1:0] cs, rs, cn, rn;
  logic [COL_W-1:0] cur_col, cur_row;
  logic [COL_W-1:0] col_right, col_left;
  logic             has_result, on_last_row, on_last_col, on_border;
  logic [DIM_W-1:0] row_up;
  logic             in_accept;

  assign in_accept = in_valid && in_ready;

  always_comb begin
    cs = frame_start ? '0 : {1'b0, col_count};
    rs = frame_start ? '0 : {1'b0, row_count};
    if (cs >= width_eff) begin
      cs = '0;
      rs = rs + DIM_W'(1);
    end
    if (rs >= height_eff) rs = '0;
    cur_col = cs[COL_W-1:0];
    cur_row = rs[COL_W-1:0];

    cn = cs + DIM_W'(1);
    rn = rs;
    if (cn >= width_eff) begin
      cn = '0;
      rn = rs + DIM_W'(1);
      if (rn >= height_eff) rn = '0;
    end
    col_count_next = cn[COL_W-1:0];
    row_count_next = rn[COL_W-1:0];

    col_right   = cur_col + COL_W'(1);
    col_left    = cur_col - COL_W'(1);
    row_up      = rs - DIM_W'(1);
    has_result  = (rs != '0);
    on_last_row = (rs == height_eff - DIM_W'(1));
    on_last_col = (cs == width_eff - DIM_W'(1));
    on_border   = (row_up == '0) || (row_up == height_eff - DIM_W'(1)) ||
                  (cs == '0) || on_last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // ------------------------------------------------------------------
  // Line buffers: line_prev holds the last row, line_prev2 the one before.
  // line_prev is updated at acceptance; line_prev2 takes the old line_prev
  // entry in the next cycle, once it has been read.
  // ------------------------------------------------------------------
  logic [VAL_W-1:0] line_prev  [LINE_DEPTH];
  logic [VAL_W-1:0] line_prev2 [LINE_DEPTH];
  logic [VAL_W-1:0] rd_center, rd_right, rd_up, rd_left;

  // stage 1 registers
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [COL_W-1:0] s1_row;
  logic [VAL_W-1:0] s1_cell;
  logic             s1_result, s1_second, s1_last_col, s1_border;
  logic             fwd_up, fwd_left;
  logic [VAL_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_center        <= line_prev[cur_col];
      rd_right         <= line_prev[col_right];
      rd_up            <= line_prev2[cur_col];
      rd_left          <= line_prev2[col_left];
      line_prev[cur_col] <= cell_value;
    end
    if (s1_valid) begin
      line_prev2[s1_col] <= rd_center;
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  // Stage 1 payload, with forwarding of the line_prev2 write that lands in
  // the same cycle as this cell's read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col      <= cur_col;
      s1_row      <= cur_row;
      s1_cell     <= cell_value;
      s1_result   <= has_result;
      s1_second   <= on_last_row;
      s1_last_col <= on_last_col;
      s1_border   <= on_border;
      fwd_up      <= s1_valid && (s1_col == cur_col);
      fwd_left    <= s1_valid && (s1_col == col_left);
      fwd_data    <= rd_center;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: neighbour sum and the two products
  // ------------------------------------------------------------------
  logic [VAL_W-1:0]          nb_up, nb_left;
  logic [VAL_W+1:0]          sum4;
  logic [VAL_W+RATE_W-1:0]   prod_center_d;
  logic [VAL_W+RATE_W+1:0]   prod_sum_d;

  always_comb begin
    nb_up   = fwd_up   ? fwd_data : rd_up;
    nb_left = fwd_left ? fwd_data : rd_left;
    sum4    = (VAL_W+2)'(nb_left) + (VAL_W+2)'(rd_right) +
              (VAL_W+2)'(nb_up) + (VAL_W+2)'(s1_cell);
    prod_center_d = (VAL_W+RATE_W)'(rd_center) * (VAL_W+RATE_W)'(rate_inv);
    prod_sum_d    = (VAL_W+RATE_W+2)'(sum4) * (VAL_W+RATE_W+2)'(rate_eff);
  end

  logic                      s2_valid;
  logic [COL_W-1:0]          s2_col;
  logic [COL_W-1:0]          s2_row;
  logic [VAL_W-1:0]          s2_cell;
  logic [VAL_W-1:0]          s2_center;
  logic                      s2_second, s2_last_col, s2_border;
  logic [VAL_W+RATE_W-1:0]   s2_prod_center;
  logic [VAL_W+RATE_W+1:0]   s2_prod_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_col         <= s1_col;
      s2_row         <= s1_row;
      s2_cell        <= s1_cell;
      s2_center      <= rd_center;
      s2_second      <= s1_second;
      s2_last_col    <= s1_last_col;
      s2_border      <= s1_border;
      s2_prod_center <= prod_center_d;
      s2_prod_sum    <= prod_sum_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: blend and truncate
  // ------------------------------------------------------------------
  localparam int ACC_W = VAL_W + RATE_W + 3;
  logic [ACC_W-1:0] acc;
  logic [VAL_W-1:0] blended;
  queue_entry_t     q_wr;

  always_comb begin
    acc     = {1'b0, s2_prod_center, 2'b00} + ACC_W'(s2_prod_sum);
    blended = s2_border ? s2_center : acc[VAL_W+9:10];
    q_wr.col      = s2_col;
    q_wr.row      = s2_row;
    q_wr.value    = blended;
    q_wr.value2   = s2_cell;
    q_wr.second   = s2_second;
    q_wr.last_col = s2_last_col;
  end

  // ------------------------------------------------------------------
  // Result queue; each entry yields one or two output transactions
  // ------------------------------------------------------------------
  queue_entry_t      queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              half;     // second result of the head entry is shown
  logic              q_push, q_pop, out_fire;
  logic [QCNT_W:0]   committed;
  queue_entry_t      head;

  assign head      = queue[rd_ptr];
  assign out_valid = (q_count != '0);
  assign out_fire  = out_valid && out_ready;
  assign q_push    = s2_valid;
  assign q_pop     = out_fire && (half || !head.second);

  // room for every transaction that could still land in the queue
  assign committed = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid) +
                     (QCNT_W+1)'(s2_valid);
  assign in_ready  = (committed < (QCNT_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (q_push) queue[wr_ptr] <= q_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
      half    <= 1'b0;
    end else begin
      if (q_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (q_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (q_push && !q_pop)      q_count <= q_count + QCNT_W'(1);
      else if (q_pop && !q_push) q_count <= q_count - QCNT_W'(1);
      if (out_fire) half <= !q_pop;
    end
  end

  // Output fields
  always_comb begin
    out_col    = head.col;
    out_row    = half ? head.row : head.row - COL_W'(1);
    out_value  = half ? head.value2 : head.value;
    run_last   = half || !head.second;
    frame_done = half && head.last_col;
  end

`ifndef SYNTHESIS
  // the queue never takes an entry it has no room for
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count != QCNT_W'(QUEUE_DEPTH)) || q_pop)
    else $error("result queue overflow");

  // the second half is only shown for an entry that has one
  a_half_valid: assert property (@(posedge clk) disable iff (rst)
    half |-> out_valid && head.second)
    else $error("second result shown without a last-row entry");

  // end of frame is flagged only on the closing result of a transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> run_last && (out_row != '0))
    else $error("frame end flagged on a non-final result");

  // an accepted cell reaches the line buffer write-back next cycle
  a_writeback: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid && (s1_col == $past(cur_col)))
    else $error("line buffer write-back lost");
`endif

endmodule
